>>> hw/rtl/incremental_pi_regulator_assert.svh
`ifndef INCREMENTAL_PI_REGULATOR_ASSERT_SVH
`define INCREMENTAL_PI_REGULATOR_ASSERT_SVH

// Condition in the same cycle.
`define IPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Condition in the following cycle.
`define IPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ipr_pkg.sv
package ipr_pkg;

    localparam int ADDR_W = 5;
    localparam int ERR_W  = 17;
    localparam int SUM_W  = 24;

    localparam logic [2:0] REG_TARGET     = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [2:0] REG_DRIVE_LOW  = 3'd3;
    localparam logic [2:0] REG_DRIVE_HIGH = 3'd4;
    localparam logic [2:0] REG_DEAD_ZONE  = 3'd5;

    localparam logic [15:0] RST_TARGET     = 16'd0;
    localparam logic [15:0] RST_PROP_GAIN  = 16'd2458;
    localparam logic [15:0] RST_INTEG_GAIN = 16'd123;
    localparam logic [15:0] RST_DRIVE_LOW  = 16'd0;
    localparam logic [15:0] RST_DRIVE_HIGH = 16'd25600;
    localparam logic [14:0] RST_DEAD_ZONE  = 15'd128;

    typedef struct packed {
        logic [15:0] target_value;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] drive_low;
        logic [15:0] drive_high;
        logic [14:0] dead_zone;
    } cfg_t;

    typedef struct packed {
        logic [15:0] drive;
        logic        at_high;
        logic        at_low;
        logic        in_dead_zone;
    } result_t;

endpackage

>>> hw/rtl/ipr_datapath.sv
module ipr_datapath (
    input  ipr_pkg::cfg_t                 cfg,
    input  logic [15:0]                   measured,
    input  logic [ipr_pkg::ERR_W-1:0]     prev_error,
    input  logic [15:0]                   held_drive,
    output logic [ipr_pkg::ERR_W-1:0]     error,
    output ipr_pkg::result_t              result
);

    logic signed [16:0] err;
    logic signed [17:0] err_x;
    logic signed [17:0] diff;
    logic signed [17:0] dz;
    logic signed [17:0] tgt_dist;
    logic signed [17:0] meas_dist;
    logic signed [33:0] prop_prod;
    logic signed [32:0] integ_prod;
    logic signed [21:0] prop_inc;
    logic signed [20:0] integ_inc;
    logic signed [22:0] inc;
    logic signed [ipr_pkg::SUM_W-1:0] base;
    logic signed [ipr_pkg::SUM_W-1:0] sum;
    logic signed [ipr_pkg::SUM_W-1:0] lim_low;
    logic signed [ipr_pkg::SUM_W-1:0] lim_high;
    logic signed [ipr_pkg::SUM_W-1:0] after_high;
    logic in_band;
    logic near_low;
    logic hit_high;
    logic hit_low;

    always_comb begin
        err        = $signed({cfg.target_value[15], cfg.target_value})
                   - $signed({measured[15], measured});
        err_x      = {err[16], err};
        diff       = err_x - $signed({prev_error[16], prev_error});
        dz         = $signed({3'b000, cfg.dead_zone});
        tgt_dist   = $signed({{2{cfg.target_value[15]}}, cfg.target_value})
                   - $signed({{2{cfg.drive_low[15]}}, cfg.drive_low});
        meas_dist  = $signed({{2{measured[15]}}, measured})
                   - $signed({{2{cfg.drive_low[15]}}, cfg.drive_low});

        prop_prod  = $signed({2'b00, cfg.prop_gain}) * diff;
        integ_prod = $signed({1'b0, cfg.integ_gain}) * err;
        prop_inc   = prop_prod[33:12];
        integ_inc  = integ_prod[32:12];
        inc        = {prop_inc[21], prop_inc} + {{2{integ_inc[20]}}, integ_inc};

        in_band    = (err_x <= dz) && (err_x >= -dz);
        near_low   = (tgt_dist < dz) && (tgt_dist > -dz)
                   && (meas_dist < dz) && (meas_dist > -dz);

        lim_low    = $signed({{8{cfg.drive_low[15]}}, cfg.drive_low});
        lim_high   = $signed({{8{cfg.drive_high[15]}}, cfg.drive_high});

        if (in_band && near_low) begin
            base = lim_low;
        end else begin
            base = $signed({{8{held_drive[15]}}, held_drive});
        end

        if (in_band) begin
            sum = base;
        end else begin
            sum = base + $signed({inc[22], inc});
        end

        hit_high   = sum >= lim_high;
        after_high = hit_high ? lim_high : sum;
        hit_low    = after_high <= lim_low;

        error               = err;
        result.drive        = hit_low ? cfg.drive_low : after_high[15:0];
        result.at_high      = hit_high;
        result.at_low       = hit_low;
        result.in_dead_zone = in_band;
    end

endmodule

>>> hw/rtl/incremental_pi_regulator.sv
// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  measured sample
// m_        out        m_valid / m_ready  drive and clamp flags
// apb       in         psel / penable     configuration registers
// One word per cycle while m_ready does not stall; m_valid rises once the
// accepted word has passed meas_reg and out_reg. The held drive and previous
// error loop is combinational: two gain multipliers and the clamp compare.
// Reset is synchronous on aresetn low; all but meas_reg and out_reg return to defaults.
// A stalled m_ side holds the result while one more input word is buffered.
module incremental_pi_regulator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_measured,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_drive,
    output logic                        m_at_high,
    output logic                        m_at_low,
    output logic                        m_in_dead_zone,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipr_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    ipr_pkg::cfg_t                cfg_reg;
    logic                         in_valid_reg;
    logic [15:0]                  meas_reg;
    logic                         out_valid_reg;
    ipr_pkg::result_t             out_reg;
    logic [ipr_pkg::ERR_W-1:0]    prev_error_reg;
    logic [15:0]                  held_drive_reg;
    logic [ipr_pkg::ERR_W-1:0]    error_next;
    ipr_pkg::result_t             out_next;
    logic                         advance;
    logic                         cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    ipr_datapath u_datapath (
        .cfg        (cfg_reg),
        .measured   (meas_reg),
        .prev_error (prev_error_reg),
        .held_drive (held_drive_reg),
        .error      (error_next),
        .result     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_value <= ipr_pkg::RST_TARGET;
            cfg_reg.prop_gain    <= ipr_pkg::RST_PROP_GAIN;
            cfg_reg.integ_gain   <= ipr_pkg::RST_INTEG_GAIN;
            cfg_reg.drive_low    <= ipr_pkg::RST_DRIVE_LOW;
            cfg_reg.drive_high   <= ipr_pkg::RST_DRIVE_HIGH;
            cfg_reg.dead_zone    <= ipr_pkg::RST_DEAD_ZONE;
        end else if (cfg_write) begin
            case (paddr[4:2])
                ipr_pkg::REG_TARGET:     cfg_reg.target_value <= pwdata[15:0];
                ipr_pkg::REG_PROP_GAIN:  cfg_reg.prop_gain    <= pwdata[15:0];
                ipr_pkg::REG_INTEG_GAIN: cfg_reg.integ_gain   <= pwdata[15:0];
                ipr_pkg::REG_DRIVE_LOW:  cfg_reg.drive_low    <= pwdata[15:0];
                ipr_pkg::REG_DRIVE_HIGH: cfg_reg.drive_high   <= pwdata[15:0];
                ipr_pkg::REG_DEAD_ZONE:  cfg_reg.dead_zone    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ipr_pkg::REG_TARGET:
                prdata = {{16{cfg_reg.target_value[15]}}, cfg_reg.target_value};
            ipr_pkg::REG_PROP_GAIN:  prdata = {16'd0, cfg_reg.prop_gain};
            ipr_pkg::REG_INTEG_GAIN: prdata = {16'd0, cfg_reg.integ_gain};
            ipr_pkg::REG_DRIVE_LOW:
                prdata = {{16{cfg_reg.drive_low[15]}}, cfg_reg.drive_low};
            ipr_pkg::REG_DRIVE_HIGH:
                prdata = {{16{cfg_reg.drive_high[15]}}, cfg_reg.drive_high};
            ipr_pkg::REG_DEAD_ZONE:  prdata = {17'd0, cfg_reg.dead_zone};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_error_reg <= '0;
            held_drive_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                prev_error_reg <= error_next;
                held_drive_reg <= out_next.drive;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            meas_reg <= s_measured;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_drive        = out_reg.drive;
    assign m_at_high      = out_reg.at_high;
    assign m_at_low       = out_reg.at_low;
    assign m_in_dead_zone = out_reg.in_dead_zone;

`include "incremental_pi_regulator_assert.svh"

    `IPR_ASSERT_NEXT(a_held_matches_out, advance, held_drive_reg == m_drive, "held drive differs from result")
    `IPR_ASSERT_NEXT(a_low_clamp_value, advance, !m_at_low || (m_drive == $past(cfg_reg.drive_low)), "low clamp value wrong")
    `IPR_ASSERT_NEXT(a_within_limits, advance && ($signed(cfg_reg.drive_low) <= $signed(cfg_reg.drive_high)), ($signed(m_drive) >= $signed($past(cfg_reg.drive_low))) && ($signed(m_drive) <= $signed($past(cfg_reg.drive_high))), "drive outside limits")
    `IPR_ASSERT_NEXT(a_input_kept, in_valid_reg && !advance, in_valid_reg && $stable(meas_reg), "buffered sample lost")

endmodule

>>> verif/tb_incremental_pi_regulator.sv
module tb_incremental_pi_regulator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [15:0]                s_measured = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [15:0]                m_drive;
    logic                       m_at_high;
    logic                       m_at_low;
    logic                       m_in_dead_zone;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [ipr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;

    ipr_pkg::cfg_t              model_regs;
    logic signed [16:0]         model_prev_err;
    logic signed [15:0]         model_held_drive;
    ipr_pkg::result_t           pending_drives[$];

    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    int                         fault_count = 0;
    int                         drive_words_checked = 0;
    int                         reg_write_count = 0;

    incremental_pi_regulator u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_measured     (s_measured),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive        (m_drive),
        .m_at_high      (m_at_high),
        .m_at_low       (m_at_low),
        .m_in_dead_zone (m_in_dead_zone),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767) begin
            return 16'h7fff;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    task automatic clear_model();
        model_regs.target_value = ipr_pkg::RST_TARGET;
        model_regs.prop_gain    = ipr_pkg::RST_PROP_GAIN;
        model_regs.integ_gain   = ipr_pkg::RST_INTEG_GAIN;
        model_regs.drive_low    = ipr_pkg::RST_DRIVE_LOW;
        model_regs.drive_high   = ipr_pkg::RST_DRIVE_HIGH;
        model_regs.dead_zone    = ipr_pkg::RST_DEAD_ZONE;
        model_prev_err          = '0;
        model_held_drive        = '0;
    endtask

    task automatic store_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            ipr_pkg::REG_TARGET: begin
                model_regs.target_value = data[15:0];
            end
            ipr_pkg::REG_PROP_GAIN: begin
                model_regs.prop_gain = data[15:0];
            end
            ipr_pkg::REG_INTEG_GAIN: begin
                model_regs.integ_gain = data[15:0];
            end
            ipr_pkg::REG_DRIVE_LOW: begin
                model_regs.drive_low = data[15:0];
            end
            ipr_pkg::REG_DRIVE_HIGH: begin
                model_regs.drive_high = data[15:0];
            end
            ipr_pkg::REG_DEAD_ZONE: begin
                model_regs.dead_zone = data[14:0];
            end
            default: begin
            end
        endcase
    endtask

    function automatic logic [15:0] model_reg(input logic [2:0] idx);
        case (idx)
            ipr_pkg::REG_TARGET:     return model_regs.target_value;
            ipr_pkg::REG_PROP_GAIN:  return model_regs.prop_gain;
            ipr_pkg::REG_INTEG_GAIN: return model_regs.integ_gain;
            ipr_pkg::REG_DRIVE_LOW:  return model_regs.drive_low;
            ipr_pkg::REG_DRIVE_HIGH: return model_regs.drive_high;
            default:                 return {1'b0, model_regs.dead_zone};
        endcase
    endfunction

    function automatic ipr_pkg::result_t regulate_step(input logic [15:0] meas);
        ipr_pkg::result_t word;
        longint  m;
        longint  tgt;
        longint  lo;
        longint  hi;
        longint  dz;
        longint  err;
        longint  total;
        logic    in_band;
        m     = longint'($signed(meas));
        tgt   = longint'($signed(model_regs.target_value));
        lo    = longint'($signed(model_regs.drive_low));
        hi    = longint'($signed(model_regs.drive_high));
        dz    = longint'(model_regs.dead_zone);
        err   = tgt - m;
        total = longint'(model_held_drive);
        in_band = (mag(err) <= dz);
        if (!in_band) begin
            total += ((longint'(model_regs.prop_gain) * (err - longint'(model_prev_err))) >>> 12)
                   + ((longint'(model_regs.integ_gain) * err) >>> 12);
        end else if (mag(tgt - lo) < dz && mag(m - lo) < dz) begin
            total = lo;
        end
        word.at_high = 1'b0;
        word.at_low  = 1'b0;
        if (total >= hi) begin
            total = hi;
            word.at_high = 1'b1;
        end
        if (total <= lo) begin
            total = lo;
            word.at_low = 1'b1;
        end
        word.drive        = total[15:0];
        word.in_dead_zone = in_band;
        model_prev_err    = err[16:0];
        model_held_drive  = total[15:0];
        return word;
    endfunction

    task automatic report_fault(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fault_count++;
    endtask

    always @(posedge aclk) begin
        ipr_pkg::result_t want;
        if (!aresetn) begin
            clear_model();
        end else begin
            if (psel && penable && pwrite && pready) begin
                store_reg(paddr[4:2], pwdata);
            end
            if (s_valid && s_ready) begin
                pending_drives.push_back(regulate_step(s_measured));
            end
            if (m_valid && m_ready) begin
                if (pending_drives.size() == 0) begin
                    report_fault("drive word arrived with nothing pending");
                end else begin
                    want = pending_drives.pop_front();
                    drive_words_checked++;
                    if (m_drive !== want.drive) begin
                        report_fault($sformatf("drive %0d, predicted %0d",
                                               $signed(m_drive), $signed(want.drive)));
                    end
                    if (m_at_high !== want.at_high) begin
                        report_fault($sformatf("at_high %b, predicted %b",
                                               m_at_high, want.at_high));
                    end
                    if (m_at_low !== want.at_low) begin
                        report_fault($sformatf("at_low %b, predicted %b",
                                               m_at_low, want.at_low));
                    end
                    if (m_in_dead_zone !== want.in_dead_zone) begin
                        report_fault($sformatf("in_dead_zone %b, predicted %b",
                                               m_in_dead_zone, want.in_dead_zone));
                    end
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        logic [31:0] noise;
        noise   = $urandom;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {noise[31:16], val};
        if (idx == ipr_pkg::REG_DEAD_ZONE) begin
            pwdata[15] = noise[15];
        end
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        reg_write_count++;
    endtask

    task automatic reg_read(input logic [2:0] idx, output logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_regs();
        logic [31:0] data;
        logic [2:0]  idx;
        for (int i = 0; i < 6; i++) begin
            idx = i[2:0];
            reg_read(idx, data);
            if (idx == ipr_pkg::REG_DEAD_ZONE ? (data[14:0] !== model_regs.dead_zone)
                                              : (data[15:0] !== model_reg(idx))) begin
                report_fault($sformatf("register %0d reads %h, expected %h",
                                       i, data, model_reg(idx)));
            end
        end
    endtask

    task automatic send_sample(input logic [15:0] meas);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_measured = meas;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending_drives.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [15:0] random_sample();
        longint dz;
        int     pick;
        dz   = longint'(model_regs.dead_zone);
        pick = $urandom_range(9);
        if (pick < 4) begin
            return 16'($urandom);
        end
        if (pick < 8) begin
            return clip16(longint'($signed(model_regs.target_value))
                          + longint'($urandom_range(32'(4 * dz + 6))) - 2 * dz - 3);
        end
        return clip16(longint'($signed(model_regs.drive_low))
                      + longint'($urandom_range(32'(2 * dz))) - dz);
    endfunction

    task automatic randomize_regs();
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic [15:0]        gain;
        logic [14:0]        dz;
        int                 r;
        r = $urandom_range(9);
        gain = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom_range(8192));
        reg_write(ipr_pkg::REG_PROP_GAIN, gain);
        r = $urandom_range(9);
        gain = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom_range(2048));
        reg_write(ipr_pkg::REG_INTEG_GAIN, gain);
        r = $urandom_range(9);
        dz = (r == 0) ? 15'd0 : (r == 1) ? 15'h7fff : 15'($urandom_range(512));
        reg_write(ipr_pkg::REG_DEAD_ZONE, {1'b0, dz});
        a = 16'($urandom);
        b = 16'($urandom);
        r = $urandom_range(9);
        if (r == 0) begin
            lo = 16'sh8000;
            hi = 16'sh7fff;
        end else if (r == 1) begin
            lo = (a > b) ? a : b;
            hi = (a > b) ? b : a;
        end else begin
            lo = (a > b) ? b : a;
            hi = (a > b) ? a : b;
        end
        reg_write(ipr_pkg::REG_DRIVE_LOW, lo);
        reg_write(ipr_pkg::REG_DRIVE_HIGH, hi);
        if ($urandom_range(9) < 3) begin
            reg_write(ipr_pkg::REG_TARGET,
                      clip16(longint'(lo) + longint'($urandom_range(32'(dz)))));
        end else if ($urandom_range(9) == 0) begin
            reg_write(ipr_pkg::REG_TARGET, ($urandom_range(1) == 0) ? 16'h8000 : 16'h7fff);
        end else begin
            reg_write(ipr_pkg::REG_TARGET, 16'($urandom));
        end
    endtask

    task automatic test_reset_values();
        check_regs();
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'd50);
        wait_idle();
    endtask

    task automatic test_dead_zone_edges();
        reg_write(ipr_pkg::REG_TARGET, 16'sd1000);
        reg_write(ipr_pkg::REG_DEAD_ZONE, 16'd100);
        send_sample(16'sd900);
        send_sample(16'sd899);
        send_sample(16'sd1100);
        send_sample(16'sd1101);
        send_sample(16'sd1000);
        wait_idle();
        reg_write(ipr_pkg::REG_TARGET, 16'sd10);
        reg_write(ipr_pkg::REG_DEAD_ZONE, 16'd20);
        send_sample(16'sd5);
        send_sample(16'sd30);
        wait_idle();
    endtask

    task automatic test_exact_limits();
        reg_write(ipr_pkg::REG_PROP_GAIN, 16'd0);
        reg_write(ipr_pkg::REG_INTEG_GAIN, 16'd4096);
        reg_write(ipr_pkg::REG_DEAD_ZONE, 16'd0);
        reg_write(ipr_pkg::REG_DRIVE_LOW, -16'sd1000);
        reg_write(ipr_pkg::REG_DRIVE_HIGH, 16'sd1000);
        reg_write(ipr_pkg::REG_TARGET, 16'sd0);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'sd1000);
        send_sample(-16'sd1000);
        send_sample(16'sd1000);
        send_sample(16'sd1000);
        wait_idle();
    endtask

    task automatic test_inverted_limits();
        reg_write(ipr_pkg::REG_DRIVE_LOW, 16'sd500);
        reg_write(ipr_pkg::REG_DRIVE_HIGH, -16'sd500);
        send_sample(16'($urandom));
        send_sample(16'($urandom));
        wait_idle();
    endtask

    task automatic test_gain_extremes();
        reg_write(ipr_pkg::REG_PROP_GAIN, 16'hffff);
        reg_write(ipr_pkg::REG_INTEG_GAIN, 16'hffff);
        reg_write(ipr_pkg::REG_DEAD_ZONE, 16'd0);
        reg_write(ipr_pkg::REG_DRIVE_LOW, 16'h8000);
        reg_write(ipr_pkg::REG_DRIVE_HIGH, 16'h7fff);
        reg_write(ipr_pkg::REG_TARGET, 16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'd0);
        wait_idle();
        reg_write(ipr_pkg::REG_PROP_GAIN, 16'd0);
        reg_write(ipr_pkg::REG_INTEG_GAIN, 16'd0);
        send_sample(16'd12345);
        wait_idle();
    endtask

    task automatic test_spare_addresses();
        reg_write(REG_SPARE_A, 16'($urandom));
        reg_write(REG_SPARE_B, 16'($urandom));
        check_regs();
    endtask

    task automatic test_random_traffic();
        int send_pct[4] = '{0, 85, 0, 37};
        int recv_pct[4] = '{0, 0, 85, 37};
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            randomize_regs();
            for (int n = 0; n < 125; n++) begin
                if (n == 62) begin
                    wait_idle();
                    randomize_regs();
                end
                send_sample(random_sample());
            end
        end
        wait_idle();
        check_regs();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_reset_values();
        test_dead_zone_edges();
        test_exact_limits();
        test_inverted_limits();
        test_gain_extremes();
        test_spare_addresses();
        test_random_traffic();
        wait_idle();
        $display("Checked %0d drive words: limit, deadband, gain and inverted-limit cases,",
                 drive_words_checked);
        $display("then random samples under four idle profiles with %0d register writes.",
                 reg_write_count);
        if (fault_count == 0 && pending_drives.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d drive words still pending.", pending_drives.size());
        $display("status: fail");
        $finish;
    end

endmodule
